// ===== design/dir_first_name_sort_unit_macros.svh =====
// Assertion macros shared by the directory sort unit
`ifndef DIR_FIRST_NAME_SORT_UNIT_MACROS_SVH
`define DIR_FIRST_NAME_SORT_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define DFNS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dfns assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define DFNS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dfns assertion failed");

`endif

// ===== design/dfns_pkg.sv =====
// Shared constants for the directory sort unit
package dfns_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int NAME_CHARS_DEF  = 16;
    localparam int OUT_INDEX_W     = 6;
    localparam logic [7:0] DOT_CHAR = 8'h2E;

endpackage

// ===== design/dfns_ram.sv =====
// Generic RAM: one write port, two read ports with registered data
module dfns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== design/dir_first_name_sort_unit.sv =====
// Top level of the directory sort unit: loader, exchange-sort sequencer, result output
// Name bytes are loaded one request per cycle while busy is low. A request with
// set_end starts the sort and raises busy; an empty set instead gives its single
// empty result the next cycle with busy staying low. The sort first seeds the rank
// table with the kept entries, then runs its outer passes, comparing each pair by
// directory flag and then byte by byte (at most NAME_CHARS + 1 bytes examined, none
// when the directory flags differ), all through one byte comparator fed by the name
// RAM's two read ports, and then reads out the results. Results come as one-cycle
// strobes on result_valid and cannot be held off; busy drops with the final result.
module dir_first_name_sort_unit #(
    parameter int MAX_ENTRIES = dfns_pkg::MAX_ENTRIES_DEF,
    parameter int NAME_CHARS  = dfns_pkg::NAME_CHARS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [7:0]                       name_char,
    input  logic                             char_valid,
    input  logic                             entry_is_dir,
    input  logic                             name_end,
    input  logic                             set_end,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_data,
    output logic                             result_valid,
    output logic [dfns_pkg::OUT_INDEX_W-1:0] out_index,
    output logic                             out_is_dir,
    output logic                             out_last,
    output logic                             out_empty
);

    import dfns_pkg::*;

`include "dir_first_name_sort_unit_macros.svh"

    localparam int IDX_W   = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int POS_W   = $clog2(NAME_CHARS + 1);
    localparam int NDEPTH  = MAX_ENTRIES * NAME_CHARS;
    localparam int NADDR_W = $clog2(NDEPTH);
    localparam int META_W  = POS_W + 1;
    localparam logic [NADDR_W-1:0] NC_A  = NADDR_W'(NAME_CHARS);
    localparam logic [POS_W-1:0]   NC_P  = POS_W'(NAME_CHARS);
    localparam logic [CNT_W-1:0]   MAX_C = CNT_W'(MAX_ENTRIES);

    typedef enum logic [3:0] {
        ST_IDLE, ST_INIT, ST_RI, ST_RI2, ST_MI, ST_RJ, ST_RJ2, ST_MJ,
        ST_CMP, ST_NEXT, ST_WI, ST_OR, ST_OR2, ST_OM
    } state_t;

    state_t state_reg, state_next;
    logic             show_hidden_reg, show_hidden_next;
    logic [CNT_W-1:0] kept_count_reg, kept_count_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             drop_reg, drop_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [POS_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [POS_W-1:0] cur_len_reg, cur_len_next;
    logic             cur_dir_reg, cur_dir_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [POS_W-1:0] jlen_reg, jlen_next;
    logic             jdir_reg, jdir_next;
    logic             swap_reg, swap_next;
    logic             result_valid_reg, result_valid_next;
    logic [OUT_INDEX_W-1:0] out_index_reg, out_index_next;
    logic             out_is_dir_reg, out_is_dir_next;
    logic             out_last_reg, out_last_next;
    logic             out_empty_reg, out_empty_next;

    // loader
    logic             accept;
    logic             kept_full;
    logic             drop_eff;
    logic [POS_W-1:0] pos_after;
    logic             close_entry;
    logic [CNT_W-1:0] kept_after;
    logic [IDX_W-1:0] last_idx;

    // memories
    logic               name_we;
    logic [NADDR_W-1:0] name_waddr, name_raddr_a, name_raddr_b;
    logic [7:0]         name_rdata_a, name_rdata_b;
    logic [POS_W-1:0]   k_rd;
    logic               meta_we;
    logic [IDX_W-1:0]   meta_raddr_a;
    logic [META_W-1:0]  meta_rdata_a, meta_rdata_b;
    logic               rank_we;
    logic [IDX_W-1:0]   rank_waddr, rank_wdata;
    logic [IDX_W-1:0]   rank_rdata_a, rank_rdata_b;

    // byte comparator
    logic signed [7:0] ca, cb;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign kept_full = (kept_count_reg >= MAX_C);
    assign last_idx  = IDX_W'(n_reg - CNT_W'(1));

    always_comb
    begin
        drop_eff = drop_reg;
        if (char_valid && pos_reg == '0)
        begin
            drop_eff = (name_char == DOT_CHAR && !show_hidden_reg) || kept_full;
        end
    end

    assign pos_after   = (char_valid && pos_reg < NC_P) ? POS_W'(pos_reg + 1'b1) : pos_reg;
    assign close_entry = name_end || (set_end && pos_after != '0);
    assign name_we     = accept && char_valid && !drop_eff && (pos_reg < NC_P) && !kept_full;
    assign meta_we     = accept && close_entry && !drop_eff && !kept_full;
    assign kept_after  = kept_count_reg + CNT_W'(meta_we);
    assign name_waddr  = NADDR_W'(kept_count_reg[IDX_W-1:0]) * NC_A + NADDR_W'(pos_reg);

    assign k_rd         = (state_reg == ST_MJ) ? '0 : POS_W'(k_reg + 1'b1);
    assign name_raddr_a = NADDR_W'(cur_reg) * NC_A + NADDR_W'(k_rd);
    assign name_raddr_b = NADDR_W'(slot_reg) * NC_A + NADDR_W'(k_rd);
    assign meta_raddr_a = (state_reg == ST_OR2) ? rank_rdata_b : rank_rdata_a;

    // end of a name reads as zero; bytes compare signed
    assign ca = (k_reg < cur_len_reg) ? name_rdata_a : 8'sd0;
    assign cb = (k_reg < jlen_reg) ? name_rdata_b : 8'sd0;

    always_comb
    begin
        rank_we    = 1'b0;
        rank_waddr = j_reg;
        rank_wdata = cur_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                rank_we    = 1'b1;
                rank_wdata = j_reg;
            end
            ST_NEXT:
            begin
                rank_we = swap_reg;
            end
            ST_WI:
            begin
                rank_we    = 1'b1;
                rank_waddr = i_reg;
            end
            default:
            begin
                rank_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        show_hidden_next  = show_hidden_reg;
        kept_count_next   = kept_count_reg;
        pos_next          = pos_reg;
        drop_next         = drop_reg;
        n_next            = n_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        k_next            = k_reg;
        cur_next          = cur_reg;
        cur_len_next      = cur_len_reg;
        cur_dir_next      = cur_dir_reg;
        slot_next         = slot_reg;
        jlen_next         = jlen_reg;
        jdir_next         = jdir_reg;
        swap_next         = swap_reg;
        result_valid_next = 1'b0;
        out_index_next    = out_index_reg;
        out_is_dir_next   = out_is_dir_reg;
        out_last_next     = out_last_reg;
        out_empty_next    = out_empty_reg;

        if (cfg_valid && cfg_ready)
        begin
            show_hidden_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kept_count_next = kept_after;
                    pos_next        = close_entry ? '0 : pos_after;
                    drop_next       = close_entry ? 1'b0 : drop_eff;
                    if (set_end)
                    begin
                        kept_count_next = '0;
                        pos_next        = '0;
                        drop_next       = 1'b0;
                        n_next          = kept_after;
                        j_next          = '0;
                        if (kept_after == '0)
                        begin
                            result_valid_next = 1'b1;
                            out_index_next    = '0;
                            out_is_dir_next   = 1'b0;
                            out_last_next     = 1'b1;
                            out_empty_next    = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_INIT;
                        end
                    end
                end
            end
            ST_INIT:
            begin
                if (j_reg == last_idx)
                begin
                    if (last_idx == '0)
                    begin
                        j_next     = '0;
                        state_next = ST_OR;
                    end
                    else
                    begin
                        i_next     = '0;
                        state_next = ST_RI;
                    end
                end
                else
                begin
                    j_next = IDX_W'(j_reg + 1'b1);
                end
            end
            ST_RI:
            begin
                state_next = ST_RI2;
            end
            ST_RI2:
            begin
                cur_next   = rank_rdata_a;
                state_next = ST_MI;
            end
            ST_MI:
            begin
                cur_len_next = meta_rdata_a[POS_W-1:0];
                cur_dir_next = meta_rdata_a[POS_W];
                j_next       = IDX_W'(i_reg + 1'b1);
                state_next   = ST_RJ;
            end
            ST_RJ:
            begin
                state_next = ST_RJ2;
            end
            ST_RJ2:
            begin
                slot_next  = rank_rdata_b;
                state_next = ST_MJ;
            end
            ST_MJ:
            begin
                jlen_next = meta_rdata_b[POS_W-1:0];
                jdir_next = meta_rdata_b[POS_W];
                if (cur_dir_reg != meta_rdata_b[POS_W])
                begin
                    // directories first: swap when the held entry is a file
                    swap_next  = !cur_dir_reg;
                    state_next = ST_NEXT;
                end
                else
                begin
                    k_next     = '0;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                priority if (ca > cb)
                begin
                    swap_next  = 1'b1;
                    state_next = ST_NEXT;
                end
                else if (ca < cb || ca == 8'sd0)
                begin
                    swap_next  = 1'b0;
                    state_next = ST_NEXT;
                end
                else
                begin
                    k_next = POS_W'(k_reg + 1'b1);
                end
            end
            ST_NEXT:
            begin
                if (swap_reg)
                begin
                    cur_next     = slot_reg;
                    cur_len_next = jlen_reg;
                    cur_dir_next = jdir_reg;
                end
                if (j_reg == last_idx)
                begin
                    state_next = ST_WI;
                end
                else
                begin
                    j_next     = IDX_W'(j_reg + 1'b1);
                    state_next = ST_RJ;
                end
            end
            ST_WI:
            begin
                if (IDX_W'(i_reg + 1'b1) == last_idx)
                begin
                    j_next     = '0;
                    state_next = ST_OR;
                end
                else
                begin
                    i_next     = IDX_W'(i_reg + 1'b1);
                    state_next = ST_RI;
                end
            end
            ST_OR:
            begin
                state_next = ST_OR2;
            end
            ST_OR2:
            begin
                slot_next  = rank_rdata_b;
                state_next = ST_OM;
            end
            ST_OM:
            begin
                result_valid_next = 1'b1;
                out_index_next    = OUT_INDEX_W'(slot_reg);
                out_is_dir_next   = meta_rdata_a[POS_W];
                out_last_next     = (j_reg == last_idx);
                out_empty_next    = 1'b0;
                if (j_reg == last_idx)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    j_next     = IDX_W'(j_reg + 1'b1);
                    state_next = ST_OR;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            show_hidden_reg  <= 1'b0;
            kept_count_reg   <= '0;
            pos_reg          <= '0;
            drop_reg         <= 1'b0;
            n_reg            <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            k_reg            <= '0;
            swap_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            out_index_reg    <= '0;
            out_is_dir_reg   <= 1'b0;
            out_last_reg     <= 1'b0;
            out_empty_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            show_hidden_reg  <= show_hidden_next;
            kept_count_reg   <= kept_count_next;
            pos_reg          <= pos_next;
            drop_reg         <= drop_next;
            n_reg            <= n_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            k_reg            <= k_next;
            swap_reg         <= swap_next;
            result_valid_reg <= result_valid_next;
            out_index_reg    <= out_index_next;
            out_is_dir_reg   <= out_is_dir_next;
            out_last_reg     <= out_last_next;
            out_empty_reg    <= out_empty_next;
        end
    end

    // working copies of the entries under compare
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        cur_len_reg <= cur_len_next;
        cur_dir_reg <= cur_dir_next;
        slot_reg    <= slot_next;
        jlen_reg    <= jlen_next;
        jdir_reg    <= jdir_next;
    end

    assign result_valid = result_valid_reg;
    assign out_index    = out_index_reg;
    assign out_is_dir   = out_is_dir_reg;
    assign out_last     = out_last_reg;
    assign out_empty    = out_empty_reg;

    dfns_ram #(
        .WIDTH(8),
        .DEPTH(NDEPTH)
    ) u_name_ram (
        .clk    (clk),
        .we     (name_we),
        .waddr  (name_waddr),
        .wdata  (name_char),
        .raddr_a(name_raddr_a),
        .rdata_a(name_rdata_a),
        .raddr_b(name_raddr_b),
        .rdata_b(name_rdata_b)
    );

    dfns_ram #(
        .WIDTH(META_W),
        .DEPTH(MAX_ENTRIES)
    ) u_meta_ram (
        .clk    (clk),
        .we     (meta_we),
        .waddr  (kept_count_reg[IDX_W-1:0]),
        .wdata  ({entry_is_dir, pos_after}),
        .raddr_a(meta_raddr_a),
        .rdata_a(meta_rdata_a),
        .raddr_b(rank_rdata_b),
        .rdata_b(meta_rdata_b)
    );

    dfns_ram #(
        .WIDTH(IDX_W),
        .DEPTH(MAX_ENTRIES)
    ) u_rank_ram (
        .clk    (clk),
        .we     (rank_we),
        .waddr  (rank_waddr),
        .wdata  (rank_wdata),
        .raddr_a(i_reg),
        .rdata_a(rank_rdata_a),
        .raddr_b(j_reg),
        .rdata_b(rank_rdata_b)
    );

    `DFNS_ASSERT_IMP(a_last_frees, result_valid_reg && out_last_reg, !busy)
    `DFNS_ASSERT_IMP(a_mid_busy, result_valid_reg && !out_last_reg, busy)
    `DFNS_ASSERT_IMP(a_empty_last, result_valid_reg && out_empty_reg, out_last_reg)
    `DFNS_ASSERT_NEXT(a_sort_starts, accept && set_end && kept_after != '0, busy)
    `DFNS_ASSERT_IMP(a_kept_bound, 1'b1, kept_count_reg <= MAX_C)
    `DFNS_ASSERT_IMP(a_pair_order, state_reg == ST_RJ, j_reg > i_reg)

endmodule

// ===== verif/dir_first_name_sort_checker.sv =====
// Checker for the directory sort unit: tracks load requests, predicts sorted ranks, compares
module dir_first_name_sort_checker #(
    parameter int MAX_ENTRIES = dfns_pkg::MAX_ENTRIES_DEF,
    parameter int NAME_CHARS  = dfns_pkg::NAME_CHARS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic [7:0]                       name_char,
    input  logic                             char_valid,
    input  logic                             entry_is_dir,
    input  logic                             name_end,
    input  logic                             set_end,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic                             cfg_data,
    input  logic                             result_valid,
    input  logic [dfns_pkg::OUT_INDEX_W-1:0] out_index,
    input  logic                             out_is_dir,
    input  logic                             out_last,
    input  logic                             out_empty,
    output int                               fail_count,
    output int                               ranks_due,
    output int                               ranks_predicted,
    output int                               ranks_checked
);
    import dfns_pkg::*;

    typedef struct packed {
        logic [OUT_INDEX_W-1:0] index;
        logic                   is_dir;
        logic                   last;
        logic                   empty;
    } sorted_rank_t;

    sorted_rank_t sorted_ranks [$];

    logic [7:0] name_bytes [MAX_ENTRIES*NAME_CHARS];
    int         name_len   [MAX_ENTRIES];
    logic       dir_flag   [MAX_ENTRIES];
    int         rank_slot  [MAX_ENTRIES];

    int   kept_entries = 0;
    int   char_pos     = 0;
    logic dropping     = 1'b0;
    logic hidden_shown = 1'b0;

    int mismatches      = 0;
    int predicted_total = 0;
    int checked_total   = 0;

    task automatic report_mismatch(input string msg);
        if (mismatches < 40)
        begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        mismatches++;
    endtask

    // end of name reads as 0; bytes compare as signed chars
    function automatic int name_byte(input int slot, input int k);
        logic signed [7:0] b;
        if (k >= name_len[slot])
        begin
            return 0;
        end
        b = name_bytes[slot*NAME_CHARS + k];
        return b;
    endfunction

    function automatic int key_order(input int a, input int b);
        int k;
        int ca;
        int cb;
        if (dir_flag[a] != dir_flag[b])
        begin
            return dir_flag[a] ? -1 : 1;
        end
        for (k = 0; k <= NAME_CHARS; k++)
        begin
            ca = name_byte(a, k);
            cb = name_byte(b, k);
            if (ca > cb)
            begin
                return 1;
            end
            if (ca < cb)
            begin
                return -1;
            end
            if (ca == 0)
            begin
                return 0;
            end
        end
        return 0;
    endfunction

    task automatic update_listing(input logic [7:0] ch, input logic cv, input logic dir,
                                  input logic ne, input logic se);
        int n;
        int i;
        int j;
        int t;
        sorted_rank_t r;
        if (cv)
        begin
            // keep/drop is decided on the first byte only
            if (char_pos == 0)
            begin
                dropping = (ch == DOT_CHAR && !hidden_shown) || kept_entries >= MAX_ENTRIES;
            end
            if (!dropping && char_pos < NAME_CHARS && kept_entries < MAX_ENTRIES)
            begin
                name_bytes[kept_entries*NAME_CHARS + char_pos] = ch;
            end
            if (char_pos < NAME_CHARS)
            begin
                char_pos++;
            end
        end
        if (ne || (se && char_pos > 0))
        begin
            if (!dropping && kept_entries < MAX_ENTRIES)
            begin
                name_len[kept_entries] = char_pos;
                dir_flag[kept_entries] = dir;
                kept_entries++;
            end
            char_pos = 0;
            dropping = 1'b0;
        end
        if (se)
        begin
            n            = kept_entries;
            kept_entries = 0;
            char_pos     = 0;
            dropping     = 1'b0;
            if (n == 0)
            begin
                r = '{index: '0, is_dir: 1'b0, last: 1'b1, empty: 1'b1};
                sorted_ranks.push_back(r);
                predicted_total++;
            end
            else
            begin
                for (i = 0; i < n; i++)
                begin
                    rank_slot[i] = i;
                end
                for (i = 0; i + 1 < n; i++)
                begin
                    for (j = i + 1; j < n; j++)
                    begin
                        if (key_order(rank_slot[i], rank_slot[j]) > 0)
                        begin
                            t            = rank_slot[i];
                            rank_slot[i] = rank_slot[j];
                            rank_slot[j] = t;
                        end
                    end
                end
                for (i = 0; i < n; i++)
                begin
                    r.index  = rank_slot[i][OUT_INDEX_W-1:0];
                    r.is_dir = dir_flag[rank_slot[i]];
                    r.last   = (i + 1 == n);
                    r.empty  = 1'b0;
                    sorted_ranks.push_back(r);
                    predicted_total++;
                end
            end
        end
    endtask

    task automatic check_rank();
        sorted_rank_t exp_rank;
        if (sorted_ranks.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing pending: index %0d dir %0b last %0b",
                                      out_index, out_is_dir, out_last));
        end
        else
        begin
            exp_rank = sorted_ranks.pop_front();
            if (out_index !== exp_rank.index)
            begin
                report_mismatch($sformatf("out_index %0d, predicted %0d",
                                          out_index, exp_rank.index));
            end
            if (out_is_dir !== exp_rank.is_dir)
            begin
                report_mismatch($sformatf("out_is_dir %0b, predicted %0b (index %0d)",
                                          out_is_dir, exp_rank.is_dir, exp_rank.index));
            end
            if (out_last !== exp_rank.last)
            begin
                report_mismatch($sformatf("out_last %0b, predicted %0b (index %0d)",
                                          out_last, exp_rank.last, exp_rank.index));
            end
            if (out_empty !== exp_rank.empty)
            begin
                report_mismatch($sformatf("out_empty %0b, predicted %0b",
                                          out_empty, exp_rank.empty));
            end
            checked_total++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            kept_entries = 0;
            char_pos     = 0;
            dropping     = 1'b0;
            hidden_shown = 1'b0;
            sorted_ranks.delete();
        end
        else
        begin
            if (result_valid)
            begin
                check_rank();
            end
            // request sees the setting from before this edge
            if (start && !busy)
            begin
                update_listing(name_char, char_valid, entry_is_dir, name_end, set_end);
            end
            if (cfg_valid && cfg_ready)
            begin
                hidden_shown = cfg_data;
            end
        end
        fail_count      <= mismatches;
        ranks_due       <= sorted_ranks.size();
        ranks_predicted <= predicted_total;
        ranks_checked   <= checked_total;
    end

endmodule

// ===== verif/dir_first_name_sort_unit_tb.sv =====
// Testbench top for the directory sort unit: stimulus, watchdog and verdict
module dir_first_name_sort_unit_tb;
    import dfns_pkg::*;

    localparam int WATCH_LIMIT = 200000;

    typedef struct packed {
        logic [7:0] ch;
        logic       cv;
        logic       dir;
        logic       ne;
        logic       se;
    } load_item_t;

    logic       clk;
    logic       rst_n        = 1'b0;
    logic       start        = 1'b0;
    logic [7:0] name_char    = 8'h00;
    logic       char_valid   = 1'b0;
    logic       entry_is_dir = 1'b0;
    logic       name_end     = 1'b0;
    logic       set_end      = 1'b0;
    logic       cfg_valid    = 1'b0;
    logic       cfg_data     = 1'b0;

    logic                   busy;
    logic                   cfg_ready;
    logic                   result_valid;
    logic [OUT_INDEX_W-1:0] out_index;
    logic                   out_is_dir;
    logic                   out_last;
    logic                   out_empty;

    int fail_count;
    int ranks_due;
    int ranks_predicted;
    int ranks_checked;

    int idle_cycles     = 0;
    int items_sent      = 0;
    int sets_sent       = 0;
    int sender_idle_pct = 0;
    int phase_items0;
    int phase_ranks0;
    int n_entries;
    int idle_pct [4]      = '{0, 63, 0, 17};
    logic show_by_phase [4] = '{1'b1, 1'b0, 1'b1, 1'b0};

    load_item_t load_items [$];

    dir_first_name_sort_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .name_char    (name_char),
        .char_valid   (char_valid),
        .entry_is_dir (entry_is_dir),
        .name_end     (name_end),
        .set_end      (set_end),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .out_index    (out_index),
        .out_is_dir   (out_is_dir),
        .out_last     (out_last),
        .out_empty    (out_empty)
    );

    dir_first_name_sort_checker u_sort_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .name_char       (name_char),
        .char_valid      (char_valid),
        .entry_is_dir    (entry_is_dir),
        .name_end        (name_end),
        .set_end         (set_end),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .out_index       (out_index),
        .out_is_dir      (out_is_dir),
        .out_last        (out_last),
        .out_empty       (out_empty),
        .fail_count      (fail_count),
        .ranks_due       (ranks_due),
        .ranks_predicted (ranks_predicted),
        .ranks_checked   (ranks_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycles with no request, no result and no register write
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        wait (idle_cycles >= WATCH_LIMIT);
        $display("watchdog: no progress for %0d cycles", WATCH_LIMIT);
        $display("tb: failure");
        $finish;
    end

    task automatic add_load(input logic [7:0] ch, input logic cv, input logic dir,
                            input logic ne, input logic se);
        load_item_t it;
        it = {ch, cv, dir, ne, se};
        load_items.push_back(it);
    endtask

    task automatic send_loads();
        load_item_t it;
        int gap;
        while (load_items.size() > 0)
        begin
            it  = load_items.pop_front();
            gap = 0;
            if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct)
            begin
                gap = $urandom_range(1, 5);
            end
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            start        <= 1'b1;
            name_char    <= it.ch;
            char_valid   <= it.cv;
            entry_is_dir <= it.dir;
            name_end     <= it.ne;
            set_end      <= it.se;
            do @(posedge clk); while (busy);
            items_sent++;
        end
    endtask

    // hold requests until every predicted rank has come out, then let the block settle
    task automatic wait_listing_drained();
        start <= 1'b0;
        do @(posedge clk); while (ranks_due != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_show_hidden(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_name_byte(input logic first);
        int r;
        r = $urandom_range(0, 99);
        if (first && r < 20)
        begin
            return DOT_CHAR;
        end
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 8'h61 + 8'($urandom_range(0, 2));
        end
        else if (r < 62)
        begin
            return 8'h80 + 8'($urandom_range(0, 127));
        end
        else if (r < 67)
        begin
            return 8'h00;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // one set of n entries; the last one closes the set in one of three ways:
    // 0 = set_end on the closing request, 1 = set_end inside the open entry,
    // 2 = separate request with only set_end
    task automatic build_listing(input int n, input int len_cap);
        int   e;
        int   k;
        int   len;
        int   mode;
        int   r;
        logic dir;
        logic last;
        logic sep_close;
        logic is_final;
        logic ne;
        logic se;
        r    = $urandom_range(0, 9);
        mode = (r < 6) ? 0 : (r < 8) ? 1 : 2;
        if (n == 0)
        begin
            mode = 2;
        end
        for (e = 0; e < n; e++)
        begin
            if ($urandom_range(0, 99) < 6)
            begin
                len = NAME_CHARS_DEF + $urandom_range(1, 3);
            end
            else
            begin
                len = $urandom_range(0, len_cap);
            end
            dir  = $urandom_range(0, 1);
            last = (e == n - 1);
            if (last && mode == 1 && len == 0)
            begin
                mode = 0;
            end
            sep_close = (len == 0) || ($urandom_range(0, 3) == 0);
            if (last && mode == 1)
            begin
                sep_close = 1'b0;
            end
            for (k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 99) < 4)
                begin
                    add_load(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                             1'b0, 1'b0);
                end
                is_final = (k == len - 1);
                ne = is_final && !sep_close && !(last && mode == 1);
                se = is_final && last && (mode == 1 || (mode == 0 && !sep_close));
                add_load(pick_name_byte(k == 0), 1'b1,
                         (ne || se) ? dir : 1'($urandom_range(0, 1)), ne, se);
            end
            if (sep_close)
            begin
                add_load(8'($urandom_range(0, 255)), 1'b0, dir, 1'b1, last && mode == 0);
            end
        end
        if (mode == 2)
        begin
            add_load(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                     1'b0, 1'b1);
        end
    endtask

    // fill the store with one-byte names, then an empty name and one more byte name
    // that both arrive once it is full
    task automatic build_full_listing();
        int e;
        for (e = 0; e < MAX_ENTRIES_DEF + 2; e++)
        begin
            if (e == MAX_ENTRIES_DEF)
            begin
                add_load(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                         1'b1, 1'b0);
            end
            else
            begin
                add_load(pick_name_byte(1'b1), 1'b1, 1'($urandom_range(0, 1)), 1'b1,
                         e == MAX_ENTRIES_DEF + 1);
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // hidden entries off (reset value): prefixes, high bytes, a zero byte,
        // a dropped dot name, an empty-named directory
        add_load(8'h61, 1'b1, 1'b1, 1'b0, 1'b0);
        add_load(8'h62, 1'b1, 1'b0, 1'b1, 1'b0);
        add_load(8'h61, 1'b1, 1'b0, 1'b1, 1'b0);
        add_load(8'h61, 1'b1, 1'b0, 1'b0, 1'b0);
        add_load(8'h80, 1'b1, 1'b0, 1'b1, 1'b0);
        add_load(8'h61, 1'b1, 1'b0, 1'b0, 1'b0);
        add_load(8'h00, 1'b1, 1'b0, 1'b1, 1'b0);
        add_load(DOT_CHAR, 1'b1, 1'b0, 1'b0, 1'b0);
        add_load(8'h68, 1'b1, 1'b0, 1'b1, 1'b0);
        add_load(8'h5a, 1'b0, 1'b1, 1'b1, 1'b0);
        add_load(8'hff, 1'b1, 1'b1, 1'b0, 1'b0);
        add_load(8'h7f, 1'b1, 1'b1, 1'b1, 1'b1);
        // no byte and no end, then a set with nothing in it
        add_load(8'h33, 1'b0, 1'b1, 1'b0, 1'b0);
        add_load(8'ha5, 1'b0, 1'b0, 1'b0, 1'b1);
        send_loads();
        sets_sent += 2;

        // show hidden, then flip the setting in the middle of a dot entry
        wait_listing_drained();
        write_show_hidden(1'b1);
        add_load(DOT_CHAR, 1'b1, 1'b0, 1'b0, 1'b0);
        add_load(8'h78, 1'b1, 1'b0, 1'b1, 1'b0);
        add_load(DOT_CHAR, 1'b1, 1'b0, 1'b0, 1'b0);
        send_loads();
        wait_listing_drained();
        write_show_hidden(1'b0);
        add_load(8'h79, 1'b1, 1'b1, 1'b1, 1'b0);
        // set_end while an entry is still open
        add_load(8'h63, 1'b1, 1'b0, 1'b0, 1'b1);
        send_loads();
        sets_sent++;
        // only a dropped entry: empty result
        add_load(DOT_CHAR, 1'b1, 1'b1, 1'b1, 1'b1);
        send_loads();
        sets_sent++;

        for (int p = 0; p < 4; p++)
        begin
            wait_listing_drained();
            write_show_hidden(show_by_phase[p]);
            sender_idle_pct = idle_pct[p];
            phase_items0    = items_sent;
            phase_ranks0    = ranks_predicted;
            while (items_sent - phase_items0 < 6 || ranks_predicted - phase_ranks0 < 3)
            begin
                n_entries = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
                build_listing(n_entries, 3);
                send_loads();
                sets_sent++;
                if ($urandom_range(0, 3) == 0)
                begin
                    wait_listing_drained();
                end
            end
            if (p == 2)
            begin
                // overfill the store with short names
                build_full_listing();
                send_loads();
                sets_sent++;
            end
        end

        start <= 1'b0;
        do @(posedge clk); while (ranks_due != 0);
        repeat (50) @(posedge clk);

        $display("run: %0d load requests in %0d sets, show_hidden at 0 and 1, store overfilled",
                 items_sent, sets_sent);
        $display("run: %0d sorted results compared, %0d mismatches", ranks_checked, fail_count);
        if (fail_count == 0 && ranks_due == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
